>>> src/gbn_rx_pkg.sv
`default_nettype none

package gbn_rx_pkg;

    // Datagram geometry.
    localparam int MAX_DATAGRAM = 2048;
    localparam int HEADER_BYTES = 81;
    localparam int POS_W        = $clog2(MAX_DATAGRAM + 1);

    // Byte positions inside the header and datagram limits.
    localparam logic [POS_W-1:0] FLAG_POS  = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] SEQ_POS   = POS_W'(15);
    localparam logic [POS_W-1:0] LEN_POS   = POS_W'(63);
    localparam logic [POS_W-1:0] CONN_LEN  = POS_W'(7);
    localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_DATAGRAM);
    localparam logic [POS_W-1:0] HDR_LIMIT = POS_W'(HEADER_BYTES);

    // Connect matcher codes.
    localparam logic [3:0] CONN_TEXT_DONE = 4'd7;
    localparam logic [3:0] CONN_ZERO_DONE = 4'd8;
    localparam logic [3:0] CONN_FAIL      = 4'd15;

    localparam logic [7:0]  ASCII_ZERO    = 8'h30;
    localparam logic [7:0]  ASCII_ONE     = 8'h31;
    localparam logic [15:0] GOOD_SUM      = 16'hFFFF;
    localparam logic [15:0] MAX_SEQ_RESET = 16'd500;

    typedef enum logic [2:0] {
        V_CSUM_ERROR   = 3'd0,
        V_STALE_DROP   = 3'd1,
        V_ACK_IN_ORDER = 3'd2,
        V_ACK_PREVIOUS = 3'd3,
        V_CONNECT_OK   = 3'd4,
        V_SHORT        = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        verdict_valid;
        verdict_t    verdict;
        logic        ack_final;
        logic [15:0] ack_seq;
        logic        commit;
        logic        file_done;
    } out_item_t;

    // Characters of the connect keyword, indexed by byte position.
    function automatic logic [7:0] conn_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h63;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h6E;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h65;
            3'd5:    ch = 8'h63;
            3'd6:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Ones-complement add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

>>> src/gbn_rx_in_slice.sv
`default_nettype none

module gbn_rx_in_slice (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire gbn_rx_pkg::in_item_t s_data,
    input  wire logic                take,
    output logic                     item_valid,
    output gbn_rx_pkg::in_item_t     item
);
    import gbn_rx_pkg::*;

    logic     valid_reg;
    in_item_t data_reg;

    // The slot refills in the same cycle that the engine consumes it.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

>>> src/gbn_rx_engine.sv
`default_nettype none

module gbn_rx_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    input  wire gbn_rx_pkg::in_item_t item,
    output logic                      take,
    input  wire logic                 res_can_load,
    output logic                      res_load,
    output gbn_rx_pkg::out_item_t     res,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [15:0]          cfg_data
);
    import gbn_rx_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      shift_reg, shift_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      len_reg, len_next;
    logic             flag_reg, flag_next;
    logic [15:0]      acc_reg, acc_next;
    logic [8:0]       pend_reg, pend_next;
    logic [3:0]       conn_reg, conn_next;
    logic [15:0]      exp_reg, exp_next;
    logic [15:0]      max_seq_reg;
    logic [15:0]      sum;
    logic [7:0]       b;
    logic             pay_valid;
    logic [7:0]       pay_byte;
    logic             has_res;
    logic             fire;

    assign b = item.data_byte;

    // Per-byte update of the datagram state.
    always_comb begin
        pos_next   = pos_reg;
        shift_next = shift_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        flag_next  = flag_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        conn_next  = conn_reg;
        pay_valid  = 1'b0;
        pay_byte   = '0;

        if (pos_reg < MAX_POS) begin
            if (pos_reg < CONN_LEN) begin
                conn_next = (conn_reg == pos_reg[3:0] && b == conn_char(pos_reg[2:0]))
                            ? pos_reg[3:0] + 4'd1 : CONN_FAIL;
            end else if (pos_reg == CONN_LEN) begin
                conn_next = (conn_reg == CONN_TEXT_DONE && b == 8'h00)
                            ? CONN_ZERO_DONE : CONN_FAIL;
            end

            if (pos_reg < FLAG_POS) begin
                shift_next = {shift_reg[14:0], b == ASCII_ONE};
                if (pos_reg[3:0] == 4'hF) begin
                    acc_next = ones_add(acc_reg, shift_next);
                    if (pos_reg == SEQ_POS) begin
                        seq_next = shift_next;
                    end else if (pos_reg == LEN_POS) begin
                        len_next = shift_next;
                    end
                end
            end else if (pos_reg == FLAG_POS) begin
                flag_next = (b != ASCII_ZERO);
                acc_next  = ones_add(acc_reg, {15'd0, flag_next});
            end else if ({{(16-POS_W){1'b0}}, pos_reg} < len_reg) begin
                pay_valid = 1'b1;
                pay_byte  = b;
                // The payload starts at an odd position, so odd positions open a pair.
                if (pos_reg[0]) begin
                    pend_next = {1'b1, b};
                end else begin
                    acc_next  = ones_add(acc_reg, {pend_reg[7:0], b});
                    pend_next = '0;
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // A pending high byte never coexists with an accumulator update in the same item.
    assign sum = pend_next[8] ? ones_add(acc_reg, {pend_next[7:0], 8'h00}) : acc_next;

    // Verdict for the last byte and the expected sequence update.
    always_comb begin
        exp_next = exp_reg;
        res.payload_valid = pay_valid;
        res.payload_byte  = pay_byte;
        res.verdict_valid = 1'b0;
        res.verdict       = V_CSUM_ERROR;
        res.ack_final     = 1'b0;
        res.ack_seq       = '0;
        res.commit        = 1'b0;
        res.file_done     = 1'b0;
        if (item.last_byte) begin
            res.verdict_valid = 1'b1;
            priority if (conn_next == CONN_TEXT_DONE || conn_next == CONN_ZERO_DONE) begin
                res.verdict = V_CONNECT_OK;
            end else if (pos_next < HDR_LIMIT) begin
                res.verdict = V_SHORT;
            end else if (sum != GOOD_SUM) begin
                res.verdict = V_CSUM_ERROR;
            end else if (seq_next < exp_reg) begin
                res.verdict = V_STALE_DROP;
            end else if (seq_next == exp_reg) begin
                res.verdict   = V_ACK_IN_ORDER;
                res.ack_final = flag_next;
                res.ack_seq   = seq_next;
                res.commit    = 1'b1;
                res.file_done = !flag_next;
                if (!flag_next || seq_next == max_seq_reg) begin
                    exp_next = '0;
                end else begin
                    exp_next = exp_reg + 16'd1;
                end
            end else begin
                res.verdict   = V_ACK_PREVIOUS;
                res.ack_final = 1'b1;
                res.ack_seq   = (exp_reg == 16'd0) ? max_seq_reg : exp_reg - 16'd1;
            end
        end
    end

    // An item with no result moves on only together with the result flow.
    assign has_res  = res.payload_valid || res.verdict_valid;
    assign fire     = item_valid && res_can_load;
    assign take     = fire;
    assign res_load = fire && has_res;

    // Datagram state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            shift_reg <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            flag_reg  <= 1'b0;
            acc_reg   <= '0;
            pend_reg  <= '0;
            conn_reg  <= '0;
            exp_reg   <= '0;
        end else if (fire) begin
            exp_reg <= exp_next;
            if (item.last_byte) begin
                pos_reg   <= '0;
                shift_reg <= '0;
                seq_reg   <= '0;
                len_reg   <= '0;
                flag_reg  <= 1'b0;
                acc_reg   <= '0;
                pend_reg  <= '0;
                conn_reg  <= '0;
            end else begin
                pos_reg   <= pos_next;
                shift_reg <= shift_next;
                seq_reg   <= seq_next;
                len_reg   <= len_next;
                flag_reg  <= flag_next;
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                conn_reg  <= conn_next;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_seq_reg <= MAX_SEQ_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_seq_reg <= cfg_data;
        end
    end

    // The position counter saturates at the datagram limit.
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_POS)
        else $error("byte position beyond datagram limit");

    // A last byte always restarts the datagram.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> pos_reg == '0 && pend_reg == '0 && acc_reg == '0)
        else $error("datagram state not cleared after last byte");

    // A delivered packet that ends a file restarts the sequence.
    a_file_done_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.file_done |=> exp_reg == 16'd0)
        else $error("expected sequence not restarted at end of file");

    // Only an in-order ack moves the expected sequence.
    a_exp_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && res.commit) |=> $stable(exp_reg))
        else $error("expected sequence changed without commit");

endmodule

`default_nettype wire

>>> src/gbn_rx_out_slice.sv
`default_nettype none

module gbn_rx_out_slice (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire gbn_rx_pkg::out_item_t res,
    output logic                       can_load,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output gbn_rx_pkg::out_item_t      m_data
);
    import gbn_rx_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    // A new result may enter as the held one leaves.
    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> src/go_back_n_packet_receiver_core.sv
// Go-back-N datagram receiver: one datagram byte per item, one item per cycle sustained
// while m_ready is high. Each byte passes an input register, combinational header
// parsing and 16-bit ones-complement checksum update, and lands in a result register.
// Header bytes other than a last byte only update internal state and give no result;
// payload bytes are echoed provisionally, and the last byte gives one verdict (checksum
// error, stale drop, in-order ack, ack of the previous sequence, connect ok or short).
// Payload is kept only when the verdict carries commit. The user must write the max_seq
// register through the cfg channel only while the block is idle; this is not enforced.

`default_nettype none

module go_back_n_packet_receiver_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire gbn_rx_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output gbn_rx_pkg::out_item_t      m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [15:0]           cfg_data
);
    import gbn_rx_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      take;
    logic      res_can_load;
    logic      res_load;
    out_item_t res;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    gbn_rx_in_slice u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    gbn_rx_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .take         (take),
        .res_can_load (res_can_load),
        .res_load     (res_load),
        .res          (res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    gbn_rx_out_slice u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .can_load (res_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
